// ----- src/brbf_pkg.sv -----
// ----------------------------------------------------------------------------
// brbf_pkg
// Shared types and constants of the byte ring buffer FIFO.
// ----------------------------------------------------------------------------
package brbf_pkg;

	localparam int unsigned DEPTH_DEFAULT     = 1024;
	localparam int unsigned MAX_BURST_DEFAULT = 64;
	localparam int unsigned CAP_RESET         = 1024;

	localparam int unsigned CAP_W      = 11;
	localparam int unsigned BYTE_W     = 8;
	localparam int unsigned COUNT_W    = 7;
	localparam int unsigned LEVEL_W    = 10;
	localparam int unsigned IN_DATA_W  = 16;
	localparam int unsigned OUT_DATA_W = 32;

	typedef enum logic [1:0] {
		OP_WRITE  = 2'd0,
		OP_READ   = 2'd1,
		OP_STATUS = 2'd2,
		OP_SPARE  = 2'd3
	} op_t;

	typedef struct packed {
		logic load;
		logic fetch;
		logic cfg_load;
	} brbf_cmd_t;

	typedef struct packed {
		logic burst_start;
		logic burst_more;
	} brbf_sts_t;

endpackage

// ----- src/byte_ring_buffer_fifo.sv -----
// ----------------------------------------------------------------------------
// byte_ring_buffer_fifo
// Byte FIFO in a circular store with one slot always kept empty.
// ----------------------------------------------------------------------------
// Input stream: tuser carries the operation (write, read burst, status),
// tdata the write byte and the burst count. Each input transfer yields one
// result, or one result per byte for a read burst, the last flagged by
// tlast. Output tuser flags a result that carries a stored byte; tdata
// holds the byte, the write-taken flag, free space and bytes held after
// the step.
// A write or status item is accepted, then its result is presented. A read
// burst passes a fetch and a result state per byte: the fetch reads the
// byte store through its registered read port, the result state presents it.
// No new input is taken until the last result of an item has transferred.
// A full buffer drops the write byte; an empty read returns one result
// without a byte.
// Reset empties the buffer and sets the capacity to the default; no
// clearing pass is needed. A capacity write (cfg channel, always ready,
// issued while idle) empties the buffer as well. When the receiver stalls,
// the pending result holds and input stays blocked.
// ----------------------------------------------------------------------------
module byte_ring_buffer_fifo #(
	parameter int unsigned DEPTH     = brbf_pkg::DEPTH_DEFAULT,
	parameter int unsigned MAX_BURST = brbf_pkg::MAX_BURST_DEFAULT
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	// [7:0] write_byte, [14:8] read_count, [15] zero
	input  logic [brbf_pkg::IN_DATA_W-1:0]  s_axis_tdata,
	// [1:0] operation
	input  logic [1:0]                      s_axis_tuser,
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	// [7:0] read_byte, [8] write_taken, [18:9] space_free,
	// [28:19] data_held, [31:29] zero
	output logic [brbf_pkg::OUT_DATA_W-1:0] m_axis_tdata,
	// [0] has_byte
	output logic                            m_axis_tuser,
	output logic                            m_axis_tlast,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [brbf_pkg::CAP_W-1:0]      cfg_data
);

	brbf_pkg::brbf_cmd_t cmd;
	brbf_pkg::brbf_sts_t sts;

	brbf_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cmd           (cmd),
		.sts           (sts)
	);

	brbf_datapath #(
		.DEPTH     (DEPTH),
		.MAX_BURST (MAX_BURST)
	) u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.sts      (sts),
		.in_data  (s_axis_tdata),
		.in_op    (s_axis_tuser),
		.cfg_data (cfg_data),
		.out_data (m_axis_tdata),
		.out_has  (m_axis_tuser),
		.out_last (m_axis_tlast)
	);

endmodule

// ----- src/brbf_ram.sv -----
// ----------------------------------------------------------------------------
// brbf_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module brbf_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ----- src/brbf_ctrl.sv -----
// ----------------------------------------------------------------------------
// brbf_ctrl
// Sequencer for the byte ring buffer: accept, fetch and present results.
// ----------------------------------------------------------------------------
module brbf_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_axis_tvalid,
	output logic               s_axis_tready,
	output logic               m_axis_tvalid,
	input  logic               m_axis_tready,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	output brbf_pkg::brbf_cmd_t cmd,
	input  brbf_pkg::brbf_sts_t sts
);

	typedef enum logic [2:0] {
		S_IDLE  = 3'b001,
		S_FETCH = 3'b010,
		S_OUT   = 3'b100
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   accept;

	assign s_axis_tready = (state_q == S_IDLE);
	assign m_axis_tvalid = (state_q == S_OUT);
	assign cfg_ready     = 1'b1;
	assign accept        = s_axis_tvalid && s_axis_tready;

	assign cmd.load     = accept;
	assign cmd.fetch    = (state_q == S_FETCH);
	assign cmd.cfg_load = cfg_valid;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					state_d = sts.burst_start ? S_FETCH : S_OUT;
				end
			end
			S_FETCH: begin
				state_d = S_OUT;
			end
			S_OUT: begin
				if (m_axis_tready) begin
					state_d = sts.burst_more ? S_FETCH : S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_axis_tready && m_axis_tvalid))
		else $error("input accepted while a result is pending");

	a_fetch_to_out: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FETCH) |=> (state_q == S_OUT))
		else $error("fetch not followed by result");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid)
		else $error("result dropped while stalled");

endmodule

// ----- src/brbf_datapath.sv -----
// ----------------------------------------------------------------------------
// brbf_datapath
// Pointers, fill level, byte store and result registers of the ring buffer.
// ----------------------------------------------------------------------------
module brbf_datapath #(
	parameter int unsigned DEPTH     = brbf_pkg::DEPTH_DEFAULT,
	parameter int unsigned MAX_BURST = brbf_pkg::MAX_BURST_DEFAULT
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  brbf_pkg::brbf_cmd_t               cmd,
	output brbf_pkg::brbf_sts_t               sts,
	input  logic [brbf_pkg::IN_DATA_W-1:0]    in_data,
	input  logic [1:0]                        in_op,
	input  logic [brbf_pkg::CAP_W-1:0]        cfg_data,
	output logic [brbf_pkg::OUT_DATA_W-1:0]   out_data,
	output logic                              out_has,
	output logic                              out_last
);

	localparam int unsigned PW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW      = $clog2(DEPTH + 1);
	localparam int unsigned BW      = $clog2(MAX_BURST + 1);
	localparam int unsigned CAP_RST =
		(brbf_pkg::CAP_RESET > DEPTH) ? DEPTH : brbf_pkg::CAP_RESET;

	logic [CW-1:0] cap_q;
	logic [PW-1:0] rd_ptr_q;
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] held_q;
	logic [BW-1:0] remain_q;
	logic          has_q;
	logic          last_q;
	logic          taken_q;

	logic [brbf_pkg::BYTE_W-1:0]  wbyte;
	logic [brbf_pkg::COUNT_W-1:0] rcount;
	logic [brbf_pkg::BYTE_W-1:0]  rdata;
	brbf_pkg::op_t                op;
	logic [31:0]                  cnt_w;
	logic [31:0]                  held_w;
	logic [31:0]                  n_w;
	logic [31:0]                  cfg_w;
	logic [31:0]                  cap_new;
	logic [31:0]                  space_w;
	logic                         full;
	logic                         do_write;
	logic [PW-1:0]                wr_ptr_nx;
	logic [PW-1:0]                rd_ptr_nx;

	assign wbyte  = in_data[brbf_pkg::BYTE_W-1:0];
	assign rcount = in_data[brbf_pkg::BYTE_W +: brbf_pkg::COUNT_W];
	assign op     = brbf_pkg::op_t'(in_op);

	assign held_w = 32'(held_q);
	assign cnt_w  = (32'(rcount) > MAX_BURST) ? MAX_BURST : 32'(rcount);
	assign n_w    = (cnt_w < held_w) ? cnt_w : held_w;
	assign full   = (held_w == 32'(cap_q) - 32'd1);

	assign do_write = cmd.load && (op == brbf_pkg::OP_WRITE) && !full;

	assign wr_ptr_nx = (CW'(wr_ptr_q) + CW'(1) == cap_q) ? '0 : wr_ptr_q + PW'(1);
	assign rd_ptr_nx = (CW'(rd_ptr_q) + CW'(1) == cap_q) ? '0 : rd_ptr_q + PW'(1);

	assign cfg_w   = 32'(cfg_data);
	assign cap_new = (cfg_w < 32'd2) ? 32'd2 : ((cfg_w > DEPTH) ? DEPTH : cfg_w);

	assign sts.burst_start = (op == brbf_pkg::OP_READ) && (n_w != 32'd0);
	assign sts.burst_more  = (remain_q != '0);

	brbf_ram #(
		.WIDTH (brbf_pkg::BYTE_W),
		.DEPTH (DEPTH)
	) u_store (
		.clk   (clk),
		.we    (do_write),
		.waddr (wr_ptr_q),
		.wdata (wbyte),
		.re    (cmd.fetch),
		.raddr (rd_ptr_q),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q    <= CW'(CAP_RST);
			rd_ptr_q <= '0;
			wr_ptr_q <= '0;
			held_q   <= '0;
			remain_q <= '0;
			has_q    <= 1'b0;
			last_q   <= 1'b1;
			taken_q  <= 1'b0;
		end else begin
			priority if (cmd.cfg_load) begin
				cap_q    <= CW'(cap_new);
				rd_ptr_q <= '0;
				wr_ptr_q <= '0;
				held_q   <= '0;
			end else if (cmd.load) begin
				has_q   <= 1'b0;
				last_q  <= 1'b1;
				taken_q <= do_write;
				if (do_write) begin
					wr_ptr_q <= wr_ptr_nx;
					held_q   <= held_q + PW'(1);
				end
				if (sts.burst_start) begin
					remain_q <= BW'(n_w);
				end
			end else if (cmd.fetch) begin
				rd_ptr_q <= rd_ptr_nx;
				held_q   <= held_q - PW'(1);
				remain_q <= remain_q - BW'(1);
				has_q    <= 1'b1;
				last_q   <= (remain_q == BW'(1));
				taken_q  <= 1'b0;
			end
		end
	end

	assign space_w = 32'(cap_q) - 32'd1 - held_w;

	assign out_data = {3'b000, held_w[brbf_pkg::LEVEL_W-1:0],
		space_w[brbf_pkg::LEVEL_W-1:0], taken_q,
		(has_q ? rdata : {brbf_pkg::BYTE_W{1'b0}})};
	assign out_has  = has_q;
	assign out_last = last_q;

	a_level_bound: assert property (@(posedge clk) disable iff (!arst_n)
		held_w < 32'(cap_q))
		else $error("fill level beyond capacity");

	a_fetch_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.fetch |-> (held_q != '0) && (remain_q != '0))
		else $error("fetch from empty buffer or finished burst");

	a_fetch_level: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.fetch && !cmd.cfg_load) |=> (held_q == $past(held_q) - PW'(1)))
		else $error("fill level not reduced by fetch");

	a_ptr_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(CW'(rd_ptr_q) < cap_q) && (CW'(wr_ptr_q) < cap_q))
		else $error("pointer beyond capacity");

endmodule
